[hw/rtl/isadma_pkg.sv]
// ----------------------------------------------------------------------------
// isadma_pkg
// Shared types, codes and port decode helpers for the ISA DMA register block.
// ----------------------------------------------------------------------------
package isadma_pkg;

	localparam int CHANNELS_PER_CONTROLLER = 4;
	localparam int NUM_CHANNELS = 2 * CHANNELS_PER_CONTROLLER;
	localparam int CH_W = $clog2(NUM_CHANNELS);
	localparam int SUB_W = $clog2(CHANNELS_PER_CONTROLLER);

	localparam logic [7:0] MASTER_END = 8'h10;
	localparam logic [7:0] SLAVE_BASE = 8'hC0;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_READ  = 2'd1,
		CMD_XFER  = 2'd2,
		CMD_NONE  = 2'd3
	} isadma_cmd_code_t;

	typedef enum logic [3:0] {
		REG_MASK       = 4'hA,
		REG_MODE       = 4'hB,
		REG_CLR_FF     = 4'hC,
		REG_MASTER_CLR = 4'hD,
		REG_CLR_MASKS  = 4'hE,
		REG_ALL_MASKS  = 4'hF
	} isadma_reg_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} isadma_state_t;

	typedef struct packed {
		logic load_in;
		logic exec;
	} isadma_cmd_t;

	typedef struct packed {
		logic            hit;
		logic [CH_W-1:0] ch;
	} isadma_page_t;

	function automatic isadma_page_t page_lookup(logic [7:0] port);
		isadma_page_t r;
		r.hit = 1'b1;
		unique case (port)
			8'h87:   r.ch = CH_W'(0);
			8'h83:   r.ch = CH_W'(1);
			8'h81:   r.ch = CH_W'(2);
			8'h82:   r.ch = CH_W'(3);
			8'h8F:   r.ch = CH_W'(4);
			8'h8B:   r.ch = CH_W'(5);
			8'h89:   r.ch = CH_W'(6);
			8'h8A:   r.ch = CH_W'(7);
			default: begin
				r.hit = 1'b0;
				r.ch = '0;
			end
		endcase
		return r;
	endfunction

	function automatic logic [15:0] put_byte(logic [15:0] old, logic hi, logic [7:0] d);
		return hi ? {d, old[7:0]} : {old[15:8], d};
	endfunction

endpackage

[hw/rtl/isadma_ctrl.sv]
// ----------------------------------------------------------------------------
// isadma_ctrl
// Request sequencer: captures one request, then executes it once the output
// register is free.
// ----------------------------------------------------------------------------
module isadma_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	output isadma_pkg::isadma_cmd_t cmd
);

	isadma_pkg::isadma_state_t state_q, state_d;
	logic out_valid_q;
	logic out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= isadma_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd.load_in = 1'b0;
		cmd.exec = 1'b0;
		in_stall = 1'b1;
		unique case (state_q)
			isadma_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d = isadma_pkg::ST_EXEC;
				end
			end
			isadma_pkg::ST_EXEC: begin
				if (out_free) begin
					cmd.exec = 1'b1;
					state_d = isadma_pkg::ST_IDLE;
				end
			end
			default: state_d = isadma_pkg::ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

[hw/rtl/isadma_datapath.sv]
// ----------------------------------------------------------------------------
// isadma_datapath
// Channel register file, port decode, transfer address generation and the
// result register.
// ----------------------------------------------------------------------------
module isadma_datapath (
	input  logic                    clk,
	input  logic                    arst_n,
	input  isadma_pkg::isadma_cmd_t cmd,
	input  logic [1:0]              command,
	input  logic [7:0]              port,
	input  logic [7:0]              write_data,
	input  logic [2:0]              xfer_channel,
	output logic [7:0]              read_data,
	output logic                    xfer_done,
	output logic [23:0]             bus_address,
	output logic                    terminal_count
);

	localparam int CH_W = isadma_pkg::CH_W;
	localparam int SUB_W = isadma_pkg::SUB_W;
	localparam int NCH = isadma_pkg::NUM_CHANNELS;
	localparam int CPC = isadma_pkg::CHANNELS_PER_CONTROLLER;

	logic [1:0]      cmd_q;
	logic [7:0]      port_q;
	logic [7:0]      wdata_q;
	logic [CH_W-1:0] xch_q;

	logic [15:0] base_addr_q  [NCH];
	logic [15:0] base_count_q [NCH];
	logic [15:0] cur_addr_q   [NCH];
	logic [15:0] cur_count_q  [NCH];
	logic [7:0]  page_q       [NCH];
	logic [5:0]  mode_q       [NCH];
	logic [NCH-1:0] mask_q;
	logic [1:0]     byte_ptr_q;

	logic [7:0]  read_data_q;
	logic        xfer_done_q;
	logic [23:0] bus_address_q;
	logic        terminal_count_q;

	isadma_pkg::isadma_page_t pg;
	logic            ctl_hit;
	logic            ctl;
	logic [3:0]      reg_idx;
	logic [CH_W-1:0] reg_ch;
	logic [CH_W-1:0] sel_ch;
	logic            hi;
	logic [15:0]     cur_a;
	logic [15:0]     cur_c;
	logic [15:0]     rd_word;
	logic [5:0]      sel_mode;
	logic [15:0]     step_a;
	logic [23:0]     xfer_addr;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			cmd_q <= command;
			port_q <= port;
			wdata_q <= write_data;
			xch_q <= xfer_channel;
		end
	end

	always_comb begin
		pg = isadma_pkg::page_lookup(port_q);
		ctl_hit = 1'b0;
		ctl = 1'b0;
		reg_idx = port_q[3:0];
		if (port_q < isadma_pkg::MASTER_END) begin
			ctl_hit = 1'b1;
		end else if (port_q[7:5] == isadma_pkg::SLAVE_BASE[7:5] && !port_q[0]) begin
			ctl_hit = 1'b1;
			ctl = 1'b1;
			reg_idx = port_q[4:1];
		end
	end

	assign reg_ch = {ctl, reg_idx[2:1]};
	assign sel_ch = (cmd_q == isadma_pkg::CMD_XFER) ? xch_q : reg_ch;
	assign hi = byte_ptr_q[ctl];
	assign cur_a = cur_addr_q[sel_ch];
	assign cur_c = cur_count_q[sel_ch];
	assign sel_mode = mode_q[sel_ch];
	assign rd_word = reg_idx[0] ? cur_c : cur_a;
	assign step_a = sel_mode[3] ? cur_a - 16'd1 : cur_a + 16'd1;
	assign xfer_addr = xch_q[CH_W-1] ? {page_q[sel_ch][7:1], cur_a, 1'b0}
	                                 : {page_q[sel_ch], cur_a};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NCH; i++) begin
				base_addr_q[i] <= '0;
				base_count_q[i] <= '0;
				cur_addr_q[i] <= '0;
				cur_count_q[i] <= '0;
				page_q[i] <= '0;
				mode_q[i] <= '0;
			end
			mask_q <= '1;
			byte_ptr_q <= '0;
		end else if (cmd.exec) begin
			unique case (cmd_q)
				isadma_pkg::CMD_WRITE: begin
					if (pg.hit) begin
						page_q[pg.ch] <= wdata_q;
					end else if (ctl_hit && !reg_idx[3]) begin
						if (!reg_idx[0]) begin
							base_addr_q[reg_ch] <= isadma_pkg::put_byte(base_addr_q[reg_ch], hi, wdata_q);
							cur_addr_q[reg_ch] <= isadma_pkg::put_byte(cur_a, hi, wdata_q);
						end else begin
							base_count_q[reg_ch] <= isadma_pkg::put_byte(base_count_q[reg_ch], hi, wdata_q);
							cur_count_q[reg_ch] <= isadma_pkg::put_byte(cur_c, hi, wdata_q);
						end
						byte_ptr_q[ctl] <= !hi;
					end else if (ctl_hit) begin
						unique case (reg_idx)
							isadma_pkg::REG_MASK: mask_q[{ctl, wdata_q[SUB_W-1:0]}] <= wdata_q[2];
							isadma_pkg::REG_MODE: mode_q[{ctl, wdata_q[SUB_W-1:0]}] <= wdata_q[7:2];
							isadma_pkg::REG_CLR_FF: byte_ptr_q[ctl] <= 1'b0;
							isadma_pkg::REG_MASTER_CLR: begin
								byte_ptr_q[ctl] <= 1'b0;
								for (int i = 0; i < CPC; i++) mask_q[{ctl, SUB_W'(i)}] <= 1'b1;
							end
							isadma_pkg::REG_CLR_MASKS: begin
								for (int i = 0; i < CPC; i++) mask_q[{ctl, SUB_W'(i)}] <= 1'b0;
							end
							isadma_pkg::REG_ALL_MASKS: begin
								for (int i = 0; i < CPC; i++) mask_q[{ctl, SUB_W'(i)}] <= wdata_q[i];
							end
							default: ;
						endcase
					end
				end
				isadma_pkg::CMD_READ: begin
					if (!pg.hit && ctl_hit && !reg_idx[3]) begin
						byte_ptr_q[ctl] <= !hi;
					end
				end
				isadma_pkg::CMD_XFER: begin
					if (!mask_q[xch_q]) begin
						if (cur_c == 16'd0) begin
							if (sel_mode[2]) begin
								cur_addr_q[xch_q] <= base_addr_q[xch_q];
								cur_count_q[xch_q] <= base_count_q[xch_q];
							end else begin
								cur_addr_q[xch_q] <= step_a;
								cur_count_q[xch_q] <= 16'hFFFF;
								mask_q[xch_q] <= 1'b1;
							end
						end else begin
							cur_addr_q[xch_q] <= step_a;
							cur_count_q[xch_q] <= cur_c - 16'd1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			read_data_q <= '0;
			xfer_done_q <= 1'b0;
			bus_address_q <= '0;
			terminal_count_q <= 1'b0;
			if (cmd_q == isadma_pkg::CMD_READ) begin
				if (pg.hit) begin
					read_data_q <= page_q[pg.ch];
				end else if (ctl_hit && !reg_idx[3]) begin
					read_data_q <= hi ? rd_word[15:8] : rd_word[7:0];
				end
			end else if (cmd_q == isadma_pkg::CMD_XFER && !mask_q[xch_q]) begin
				xfer_done_q <= 1'b1;
				bus_address_q <= xfer_addr;
				terminal_count_q <= (cur_c == 16'd0);
			end
		end
	end

	assign read_data = read_data_q;
	assign xfer_done = xfer_done_q;
	assign bus_address = bus_address_q;
	assign terminal_count = terminal_count_q;

endmodule

[hw/rtl/isa_dma_controller_registers.sv]
// ----------------------------------------------------------------------------
// isa_dma_controller_registers
// Port-level model of two cascaded 8237A-style DMA controllers with page
// registers: port writes, port reads and single channel transfers.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  in      | in_valid / in_stall  | command, port, write_data, xfer_channel
//  out     | out_valid / out_stall| read_data, xfer_done, bus_address, terminal_count
//
//  Each request is first captured, then executed into the result register.
//  Execute waits while the previous result is still held under out_stall.
//  A new request is taken while a finished result waits to be collected.
//  Reset is asynchronous; all channel registers clear, all channels masked.
// ----------------------------------------------------------------------------
module isa_dma_controller_registers (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [7:0]  port,
	input  logic [7:0]  write_data,
	input  logic [2:0]  xfer_channel,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  read_data,
	output logic        xfer_done,
	output logic [23:0] bus_address,
	output logic        terminal_count
);

	isadma_pkg::isadma_cmd_t cmd;

	isadma_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	isadma_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.command        (command),
		.port           (port),
		.write_data     (write_data),
		.xfer_channel   (xfer_channel),
		.read_data      (read_data),
		.xfer_done      (xfer_done),
		.bus_address    (bus_address),
		.terminal_count (terminal_count)
	);

endmodule
